[rtl/core/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared constants, types and helpers for the quaternion to Euler core
// Fixed-point widths, CORDIC arctangent table and the output rounding step.
// ----------------------------------------------------------------------------
package qte_pkg;

  // Sample format
  localparam int SAMPLE_W     = 16;
  localparam int FRAC_BITS    = SAMPLE_W - 2;

  // Product sums and CORDIC operands (signed)
  localparam int IN_W         = 35;
  localparam int TW           = 32;
  localparam logic signed [IN_W-1:0] ONE_Q = IN_W'(64'sd1 <<< (2 * FRAC_BITS));
  localparam logic signed [IN_W-1:0] T_MAX = ONE_Q;
  localparam logic signed [IN_W-1:0] T_MIN = -ONE_Q;
  localparam int T_SHIFT      = 30 - 2 * FRAC_BITS;

  // Square root of 2^60 - t^2
  localparam int RAD_W        = 61;
  localparam int SQ_W         = 62;
  localparam int SQRT_STEPS   = 31;
  localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << (RAD_W - 1);

  // Normalization window: max(|x|,|y|) in [2^41, 2^42)
  localparam int NORM_TOP     = 42;
  localparam int NW           = 44;
  localparam int MAG_W        = 43;

  // CORDIC datapath
  localparam int CW           = 46;
  localparam int ZW           = 26;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CORDIC_LAT   = 4 + CORDIC_ITERS;
  localparam logic signed [ZW-1:0] ROT90 = ZW'(90 * 65536);

  // arctan(2^-i) in units of 2^-16 degree
  localparam logic signed [ZW-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379), ZW'(117304),
    ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334), ZW'(3667), ZW'(1833),
    ZW'(917), ZW'(458), ZW'(229), ZW'(115), ZW'(57), ZW'(29),
    ZW'(14), ZW'(7), ZW'(4), ZW'(2), ZW'(1), ZW'(0)
  };

  // Pipeline alignment
  localparam int ALIGN_DLY    = 2 + SQRT_STEPS;
  localparam int PIPE_DEPTH   = 2 + ALIGN_DLY + CORDIC_LAT + 1;

  // Output ranges
  localparam int OUT_W        = 16;
  localparam int PITCH_W      = 15;
  localparam logic [OUT_W-1:0] ROLL_LIM  = OUT_W'(23040);
  localparam logic [OUT_W-1:0] PITCH_LIM = OUT_W'(11520);

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic [MAG_W-1:0]     m;
  } norm_t;

  // One binary step of the normalizing left shift
  function automatic norm_t norm_step(norm_t a, int unsigned s);
    norm_t r;
    r = a;
    if ((a.m >> (NORM_TOP - s)) == '0) begin
      r.x = a.x <<< s;
      r.y = a.y <<< s;
      r.m = a.m << s;
    end
    return r;
  endfunction

  // Angle/512, rounded half away from zero, saturated to +/-lim
  function automatic logic signed [OUT_W-1:0] to_output(logic signed [ZW-1:0] z,
                                                      logic [OUT_W-1:0] lim);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] rnd;
    logic [ZW-1:0] lim_w;
    logic [ZW-1:0] sat;
    mag   = z[ZW-1] ? ZW'(-z) : ZW'(z);
    rnd   = (mag + ZW'(256)) >> 9;
    lim_w = ZW'(lim);
    sat   = (rnd > lim_w) ? lim_w : rnd;
    return z[ZW-1] ? -OUT_W'(sat) : OUT_W'(sat);
  endfunction

endpackage

[rtl/core/quaternion_to_euler_degrees_core.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_core: quaternion to ZYX roll, pitch, yaw
// Fully pipelined fixed-point conversion using CORDIC and a digit square root.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one quaternion per beat (real, i, j, k; Q2.14 signed).
//   m_* channel delivers one beat with roll, pitch and yaw in degrees * 128.
//   The path from an accepted input beat to its output beat runs through
//   the 31-stage square root ahead of the pitch CORDIC (20 stages).
//   Throughput is one beat per cycle while the receiver does not stall.
//   Roll and yaw CORDICs run early and their angles are delayed to line up
//   with pitch.
//   Reset (rst, synchronous) clears all stage valid bits; data registers
//   are not reset.
//   When the receiver stalls with a beat waiting, the whole pipeline holds
//   and s_tready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_real[15:0], quat_i[31:16], quat_j[47:32], quat_k[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // roll_deg[15:0], pitch_deg[30:16], yaw_deg[46:31], zero pad
);

  localparam int SW  = qte_pkg::SAMPLE_W;
  localparam int DLY = qte_pkg::ALIGN_DLY;

  logic en;
  logic [qte_pkg::PIPE_DEPTH-1:0] vld;

  logic signed [SW-1:0] q_r, q_i, q_j, q_k;
  logic signed [2*SW-1:0] p_ri, p_jk, p_ii, p_jj, p_rj, p_ki, p_rk, p_ij, p_kk;
  logic signed [qte_pkg::IN_W-1:0] t0, t1, t3, t4, tp, tc;
  logic signed [qte_pkg::TW-1:0]   tq;
  logic signed [2*qte_pkg::TW-1:0] tsq_full;
  logic [qte_pkg::RAD_W-1:0]       tsq;

  logic [qte_pkg::SQ_W-1:0] sv [0:qte_pkg::SQRT_STEPS];
  logic [qte_pkg::SQ_W-1:0] sr [0:qte_pkg::SQRT_STEPS];
  logic signed [qte_pkg::TW-1:0] td [0:DLY-1];
  logic signed [qte_pkg::ZW-1:0] zr_d [0:DLY-1];
  logic signed [qte_pkg::ZW-1:0] zy_d [0:DLY-1];

  logic signed [qte_pkg::ZW-1:0] z_roll, z_yaw, z_pitch;
  logic signed [qte_pkg::IN_W-1:0] pc_x, pc_y;
  logic signed [qte_pkg::OUT_W-1:0] pitch_full;

  // Stall the whole pipeline only while the output beat waits
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;
  assign m_tvalid = vld[qte_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[qte_pkg::PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  assign q_r = s_tdata[15:0];
  assign q_i = s_tdata[31:16];
  assign q_j = s_tdata[47:32];
  assign q_k = s_tdata[63:48];

  // Stage 1: component products
  always_ff @(posedge clk) begin
    if (en) begin
      p_ri <= q_r * q_i;
      p_jk <= q_j * q_k;
      p_ii <= q_i * q_i;
      p_jj <= q_j * q_j;
      p_rj <= q_r * q_j;
      p_ki <= q_k * q_i;
      p_rk <= q_r * q_k;
      p_ij <= q_i * q_j;
      p_kk <= q_k * q_k;
    end
  end

  // Stage 2: product sums, clamped pitch term rescaled to 30 fraction bits
  always_comb begin
    tp = (qte_pkg::IN_W'(p_rj) - qte_pkg::IN_W'(p_ki)) <<< 1;
    if (tp > qte_pkg::T_MAX) begin
      tc = qte_pkg::T_MAX;
    end else if (tp < qte_pkg::T_MIN) begin
      tc = qte_pkg::T_MIN;
    end else begin
      tc = tp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= (qte_pkg::IN_W'(p_ri) + qte_pkg::IN_W'(p_jk)) <<< 1;
      t1 <= qte_pkg::ONE_Q - ((qte_pkg::IN_W'(p_ii) + qte_pkg::IN_W'(p_jj)) <<< 1);
      t3 <= (qte_pkg::IN_W'(p_rk) + qte_pkg::IN_W'(p_ij)) <<< 1;
      t4 <= qte_pkg::ONE_Q - ((qte_pkg::IN_W'(p_jj) + qte_pkg::IN_W'(p_kk)) <<< 1);
      tq <= qte_pkg::TW'(tc <<< qte_pkg::T_SHIFT);
    end
  end

  // Stages 3-4: radicand 2^60 - t^2
  assign tsq_full = tq * tq;

  always_ff @(posedge clk) begin
    if (en) begin
      tsq   <= tsq_full[qte_pkg::RAD_W-1:0];
      sv[0] <= qte_pkg::SQ_W'(qte_pkg::RAD_ONE - tsq);
      sr[0] <= '0;
    end
  end

  // Square root, one result digit per stage
  for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [qte_pkg::SQ_W-1:0] BIT = qte_pkg::SQ_W'(1) << (qte_pkg::RAD_W - 1 - 2 * k);
    always_ff @(posedge clk) begin
      if (en) begin
        if (sv[k] >= sr[k] + BIT) begin
          sv[k+1] <= sv[k] - (sr[k] + BIT);
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  // Pitch sine term follows the square root
  always_ff @(posedge clk) begin
    if (en) begin
      td[0] <= tq;
    end
  end

  for (genvar d = 1; d < DLY; d++) begin : g_tdly
    always_ff @(posedge clk) begin
      if (en) begin
        td[d] <= td[d-1];
      end
    end
  end

  assign pc_x = qte_pkg::IN_W'(sr[qte_pkg::SQRT_STEPS][30:0]);
  assign pc_y = qte_pkg::IN_W'(td[DLY-1]);

  qte_cordic u_roll (
    .clk  (clk),
    .en   (en),
    .xin  (t1),
    .yin  (t0),
    .zout (z_roll)
  );

  qte_cordic u_yaw (
    .clk  (clk),
    .en   (en),
    .xin  (t4),
    .yin  (t3),
    .zout (z_yaw)
  );

  qte_cordic u_pitch (
    .clk  (clk),
    .en   (en),
    .xin  (pc_x),
    .yin  (pc_y),
    .zout (z_pitch)
  );

  // Roll and yaw angles wait for pitch
  always_ff @(posedge clk) begin
    if (en) begin
      zr_d[0] <= z_roll;
      zy_d[0] <= z_yaw;
    end
  end

  for (genvar d = 1; d < DLY; d++) begin : g_zdly
    always_ff @(posedge clk) begin
      if (en) begin
        zr_d[d] <= zr_d[d-1];
        zy_d[d] <= zy_d[d-1];
      end
    end
  end

  // Output register: round, saturate, pack
  assign pitch_full = qte_pkg::to_output(z_pitch, qte_pkg::PITCH_LIM);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0,
                  qte_pkg::to_output(zy_d[DLY-1], qte_pkg::ROLL_LIM),
                  pitch_full[qte_pkg::PITCH_W-1:0],
                  qte_pkg::to_output(zr_d[DLY-1], qte_pkg::ROLL_LIM)};
    end
  end

endmodule

[rtl/core/qte_cordic.sv]
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring CORDIC giving atan2(y, x)
// Three normalize stages, a quadrant fold, then one stage per iteration.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [qte_pkg::IN_W-1:0]   xin,
  input  logic signed [qte_pkg::IN_W-1:0]   yin,
  output logic signed [qte_pkg::ZW-1:0]     zout
);

  localparam int ITERS = qte_pkg::CORDIC_ITERS;

  qte_pkg::norm_t n0, n1, n2, n3;
  qte_pkg::norm_t n1_next, n2_next, n3_next;
  logic           zero1, zero2, zero3;
  logic signed [qte_pkg::NW-1:0] x0, y0, ax, ay;

  logic signed [qte_pkg::CW-1:0] xs [0:ITERS];
  logic signed [qte_pkg::CW-1:0] ys [0:ITERS];
  logic signed [qte_pkg::ZW-1:0] zs [0:ITERS];
  logic                          zf [0:ITERS];

  // Magnitude and the shift steps of all three normalize stages
  always_comb begin
    x0      = {{(qte_pkg::NW - qte_pkg::IN_W){xin[qte_pkg::IN_W-1]}}, xin};
    y0      = {{(qte_pkg::NW - qte_pkg::IN_W){yin[qte_pkg::IN_W-1]}}, yin};
    ax      = x0[qte_pkg::NW-1] ? -x0 : x0;
    ay      = y0[qte_pkg::NW-1] ? -y0 : y0;
    n0.x    = x0;
    n0.y    = y0;
    n0.m    = (ax > ay) ? ax[qte_pkg::MAG_W-1:0] : ay[qte_pkg::MAG_W-1:0];
    n1_next = qte_pkg::norm_step(qte_pkg::norm_step(n0, 32), 16);
    n2_next = qte_pkg::norm_step(qte_pkg::norm_step(n1, 8), 4);
    n3_next = qte_pkg::norm_step(qte_pkg::norm_step(n2, 2), 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1    <= n1_next;
      zero1 <= (xin == '0) && (yin == '0);
      n2    <= n2_next;
      zero2 <= zero1;
      n3    <= n3_next;
      zero3 <= zero2;
    end
  end

  // Fold a left half-plane vector by +/-90 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= zero3;
      if (n3.x < 0) begin
        if (n3.y >= 0) begin
          xs[0] <= qte_pkg::CW'(n3.y);
          ys[0] <= -qte_pkg::CW'(n3.x);
          zs[0] <= qte_pkg::ROT90;
        end else begin
          xs[0] <= -qte_pkg::CW'(n3.y);
          ys[0] <= qte_pkg::CW'(n3.x);
          zs[0] <= -qte_pkg::ROT90;
        end
      end else begin
        xs[0] <= qte_pkg::CW'(n3.x);
        ys[0] <= qte_pkg::CW'(n3.y);
        zs[0] <= '0;
      end
    end
  end

  // Micro-rotations, one per stage
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + qte_pkg::ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - qte_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  // atan2(0, 0) is zero
  assign zout = zf[ITERS] ? '0 : zs[ITERS];

endmodule

[rtl/core/qte_checker.sv]
// ----------------------------------------------------------------------------
// qte_checker: port-level checks for the quaternion to Euler core
// Output hold under stall, reset behavior, ready logic and pitch range.
// ----------------------------------------------------------------------------
module qte_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // Stalled output beat stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped under stall");

  // Stalled output beat keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output data changed under stall");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // No waiting output beat means input is taken
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Pitch stays within +/-90 degrees
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd11520) &&
                 ($signed(m_tdata[30:16]) >= -15'sd11520))
    else $error("pitch out of range");

endmodule

bind quaternion_to_euler_degrees_core qte_checker u_qte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for quaternion_to_euler_degrees_core
// Drives quaternion beats with random gaps, predicts roll/pitch/yaw with an
// integer CORDIC model and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int LAT = 56;

  // Expected-angle store and checker
  class euler_scoreboard;
    logic [47:0] pending[$];
    int unsigned n_bad;

    function void note_quat(logic [47:0] exp_beat);
      pending.push_back(exp_beat);
    endfunction

    function void check_angles(logic [47:0] got);
      logic [47:0] exp_beat;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected output beat %h", got);
        return;
      end
      exp_beat = pending.pop_front();
      if (got[15:0] !== exp_beat[15:0] || got[30:16] !== exp_beat[30:16] ||
          got[46:31] !== exp_beat[46:31] || got[47] !== 1'b0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                   $signed(exp_beat[15:0]), $signed(got[15:0]),
                   $signed(exp_beat[30:16]), $signed(got[30:16]),
                   $signed(exp_beat[46:31]), $signed(got[46:31]));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  bit          hold_off = 1'b0;

  euler_scoreboard sb;

  quaternion_to_euler_degrees_core uut (.*);

  always #6 clk = ~clk;

  localparam longint ATAN_UNITS [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else res = res >>> 1;
      b = b >>> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC angle in 2^-16 degree units
  function automatic longint angle_of(longint y, longint x);
    longint z, m, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    m = mag64(x) > mag64(y) ? mag64(x) : mag64(y);
    while (m >= (64'sd1 <<< 42)) begin
      x = x >>> 1; y = y >>> 1; m = m >>> 1;
    end
    while (m < (64'sd1 <<< 41)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int s = 0; s < 16; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_UNITS[s];
      end else begin
        x -= dx; y += dy; z -= ATAN_UNITS[s];
      end
    end
    return z;
  endfunction

  function automatic longint deg128(longint z, longint lim);
    longint r;
    r = (mag64(z) + 256) >>> 9;
    if (z < 0) r = -r;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [47:0] euler_of(logic [63:0] q);
    longint r, i, j, k, one, t0, t1, t2, t3, t4, c;
    logic [47:0] o;
    r = longint'($signed(q[15:0]));
    i = longint'($signed(q[31:16]));
    j = longint'($signed(q[47:32]));
    k = longint'($signed(q[63:48]));
    one = 64'sd1 <<< 28;
    t0 = 2 * (r * i + j * k);
    t1 = one - 2 * (i * i + j * j);
    t2 = 2 * (r * j - k * i);
    t3 = 2 * (r * k + i * j);
    t4 = one - 2 * (j * j + k * k);
    if (t2 > one) t2 = one;
    if (t2 < -one) t2 = -one;
    t2 = t2 * 4;
    c = isqrt((64'sd1 <<< 60) - t2 * t2);
    o = '0;
    o[15:0]  = 16'(deg128(angle_of(t0, t1), 23040));
    o[30:16] = 15'(deg128(angle_of(t2, c), 11520));
    o[46:31] = 16'(deg128(angle_of(t3, t4), 23040));
    return o;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Offer one beat, holding valid until accepted
  task automatic send_quat(logic [63:0] q);
    s_tdata  <= q;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_quat(euler_of(q));
  endtask

  // Drop valid and wait, unless n is zero
  task automatic idle_cycles(int n);
    if (n > 0) s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 32768) - 16384);
      1: return 16'($urandom);
      2: return 16'($urandom_range(0, 6) * 8192 - 24576);
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  // Roughly unit quaternion with random direction
  function automatic logic [63:0] unit_quat();
    real a, b, c, d, n;
    a = $urandom_range(0, 20000) - 10000.0;
    b = $urandom_range(0, 20000) - 10000.0;
    c = $urandom_range(0, 20000) - 10000.0;
    d = $urandom_range(0, 20000) - 10000.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    return {16'($rtoi(d / n * 16384)), 16'($rtoi(c / n * 16384)),
            16'($rtoi(b / n * 16384)), 16'($rtoi(a / n * 16384))};
  endfunction

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_angles(m_tdata);
      m_tready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: identity, axes, zero, extremes, gimbal lock, negative x
    send_quat({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    send_quat({16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_quat({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    send_quat({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send_quat({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    send_quat({16'sd0, 16'sd0, 16'sd11585, 16'sd11585});
    send_quat({16'sd0, 16'sd0, -16'sd11585, 16'sd11585});
    send_quat({16'sd0, -16'sd16384, 16'sd16384, 16'sd16384});
    send_quat({-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
    send_quat({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_quat({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_quat({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_quat({16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_quat({16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
    send_quat({16'sd0, 16'sd0, 16'sd1, 16'sd0});
    send_quat({16'sd0, 16'sd0, -16'sd1, 16'sd0});
    // back-to-back while the receiver holds off: pipeline fills, input stalls
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 120; n++) send_quat(unit_quat());
    join
    // pause until everything has drained
    idle_cycles(1);
    while (sb.pending.size() != 0) @(posedge clk);
    for (int n = 0; n < 1200; n++) begin
      if (n % 300 == 150) begin
        // burst with no gaps
        for (int b = 0; b < 40; b++) send_quat(unit_quat());
      end
      if ($urandom_range(0, 3) == 0)
        send_quat({rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()});
      else
        send_quat(unit_quat());
      idle_cycles(gap_len());
    end
    idle_cycles(1);
    while (sb.pending.size() != 0) @(posedge clk);
    idle_cycles(LAT + 20);
    if (sb.n_bad == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
